### rtl/cgr_pkg.sv
// Shared types, constants and helper functions of the channel gain remapper.
package cgr_pkg;

	localparam int LANES            = 8;
	localparam int GAIN_W           = 16;
	localparam int COUNT_W          = 4;
	localparam int MAX_CHANNELS_DEF = 8;
	localparam int PSUM_W           = GAIN_W + 1;
	localparam int SUM_W            = GAIN_W + 3;
	localparam int RECIP_SHIFT      = 24;
	localparam int RECIP_W          = RECIP_SHIFT + 1;
	localparam int PROD_W           = SUM_W + RECIP_W;

	typedef logic [GAIN_W-1:0]             gain_t;
	typedef logic [LANES-1:0][GAIN_W-1:0]  gains_t;
	typedef logic [COUNT_W-1:0]            count_t;
	typedef logic [2*COUNT_W-1:0]          pair_t;
	typedef logic [PSUM_W-1:0]             psum_t;
	typedef logic [SUM_W-1:0]              sum_t;
	typedef logic [RECIP_W-1:0]            recip_t;
	typedef logic [PROD_W-1:0]             prod_t;
	typedef logic [2:0]                    mode_t;

	localparam mode_t MODE_BAD   = 3'd0;
	localparam mode_t MODE_COPY  = 3'd1;
	localparam mode_t MODE_MEAN  = 3'd2;
	localparam mode_t MODE_BCAST = 3'd3;
	localparam mode_t MODE_MAP   = 3'd4;

	// Channel pairs of the fixed map, source count in the upper nibble.
	localparam pair_t PAIR_2_3 = 8'h23;
	localparam pair_t PAIR_2_4 = 8'h24;
	localparam pair_t PAIR_2_5 = 8'h25;
	localparam pair_t PAIR_2_6 = 8'h26;
	localparam pair_t PAIR_3_2 = 8'h32;
	localparam pair_t PAIR_3_4 = 8'h34;
	localparam pair_t PAIR_3_5 = 8'h35;
	localparam pair_t PAIR_3_6 = 8'h36;
	localparam pair_t PAIR_4_2 = 8'h42;
	localparam pair_t PAIR_4_3 = 8'h43;
	localparam pair_t PAIR_4_5 = 8'h45;
	localparam pair_t PAIR_4_6 = 8'h46;
	localparam pair_t PAIR_5_2 = 8'h52;
	localparam pair_t PAIR_5_3 = 8'h53;
	localparam pair_t PAIR_5_4 = 8'h54;
	localparam pair_t PAIR_5_6 = 8'h56;
	localparam pair_t PAIR_6_2 = 8'h62;
	localparam pair_t PAIR_6_3 = 8'h63;
	localparam pair_t PAIR_6_4 = 8'h64;
	localparam pair_t PAIR_6_5 = 8'h65;

	// Rounded-up reciprocals; with a 19-bit numerator the scaled product
	// floors to the exact quotient for every divisor from 1 to 8.
	localparam longint RECIP_ONE = longint'(1) << RECIP_SHIFT;
	localparam recip_t RECIP_1   = recip_t'(RECIP_ONE);
	localparam recip_t RECIP_2   = recip_t'((RECIP_ONE + 1) / 2);
	localparam recip_t RECIP_3   = recip_t'((RECIP_ONE + 2) / 3);
	localparam recip_t RECIP_4   = recip_t'((RECIP_ONE + 3) / 4);
	localparam recip_t RECIP_5   = recip_t'((RECIP_ONE + 4) / 5);
	localparam recip_t RECIP_6   = recip_t'((RECIP_ONE + 5) / 6);
	localparam recip_t RECIP_7   = recip_t'((RECIP_ONE + 6) / 7);
	localparam recip_t RECIP_8   = recip_t'((RECIP_ONE + 7) / 8);

	typedef struct packed {
		mode_t  mode;
		pair_t  pair;
		count_t dst;
	} ctl_t;

	// Contents of the first pipeline stage.
	typedef struct packed {
		ctl_t                ctl;
		gains_t              x;
		logic [3:0][PSUM_W-1:0] psum;
		psum_t               s01;
		psum_t               s23;
		gain_t               h01;
		gain_t               h02;
		gain_t               h13;
		gain_t               h03;
		gain_t               h14;
		gain_t               h04;
		gain_t               h15;
		recip_t              recip;
	} front_t;

	// Contents of the second pipeline stage.
	typedef struct packed {
		ctl_t   ctl;
		gains_t y;
		sum_t   sum;
		recip_t recip;
	} map_t;

	// Contents of the third pipeline stage.
	typedef struct packed {
		ctl_t   ctl;
		gains_t y;
		prod_t  prod;
	} mean_t;

	function automatic gain_t half2(gain_t a, gain_t b);
		psum_t t;
		t = {1'b0, a} + {1'b0, b};
		return t[PSUM_W-1:1];
	endfunction

	function automatic recip_t recip_of(count_t s);
		recip_t r;
		case (s)
			4'd1:    r = RECIP_1;
			4'd2:    r = RECIP_2;
			4'd3:    r = RECIP_3;
			4'd4:    r = RECIP_4;
			4'd5:    r = RECIP_5;
			4'd6:    r = RECIP_6;
			4'd7:    r = RECIP_7;
			4'd8:    r = RECIP_8;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### rtl/cgr_in_if.sv
// Request channel: channel counts and source gains.
interface cgr_in_if;
	logic               valid;
	logic               ready;
	cgr_pkg::count_t    src_count;
	cgr_pkg::count_t    dst_count;
	cgr_pkg::gain_t     in_gain_0;
	cgr_pkg::gain_t     in_gain_1;
	cgr_pkg::gain_t     in_gain_2;
	cgr_pkg::gain_t     in_gain_3;
	cgr_pkg::gain_t     in_gain_4;
	cgr_pkg::gain_t     in_gain_5;
	cgr_pkg::gain_t     in_gain_6;
	cgr_pkg::gain_t     in_gain_7;

	modport source (output valid, src_count, dst_count, in_gain_0, in_gain_1, in_gain_2,
		in_gain_3, in_gain_4, in_gain_5, in_gain_6, in_gain_7, input ready);
	modport sink (input valid, src_count, dst_count, in_gain_0, in_gain_1, in_gain_2,
		in_gain_3, in_gain_4, in_gain_5, in_gain_6, in_gain_7, output ready);
endinterface

### rtl/cgr_out_if.sv
// Response channel: status and destination gains.
interface cgr_out_if;
	logic               valid;
	logic               ready;
	logic               status;
	cgr_pkg::gain_t     out_gain_0;
	cgr_pkg::gain_t     out_gain_1;
	cgr_pkg::gain_t     out_gain_2;
	cgr_pkg::gain_t     out_gain_3;
	cgr_pkg::gain_t     out_gain_4;
	cgr_pkg::gain_t     out_gain_5;
	cgr_pkg::gain_t     out_gain_6;
	cgr_pkg::gain_t     out_gain_7;

	modport source (output valid, status, out_gain_0, out_gain_1, out_gain_2, out_gain_3,
		out_gain_4, out_gain_5, out_gain_6, out_gain_7, input ready);
	modport sink (input valid, status, out_gain_0, out_gain_1, out_gain_2, out_gain_3,
		out_gain_4, out_gain_5, out_gain_6, out_gain_7, output ready);
endinterface

### rtl/cgr_front.sv
// Stage 1: count decode, channel masking and the first level of gain sums.
module cgr_front #(
	parameter int MAX_CHANNELS = cgr_pkg::MAX_CHANNELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  cgr_pkg::count_t   src_count,
	input  cgr_pkg::count_t   dst_count,
	input  cgr_pkg::gains_t   in_gain,
	input  logic              down_ready,
	output logic              valid_s1,
	output cgr_pkg::front_t   front_s1
);

	localparam cgr_pkg::count_t MAX_COUNT = cgr_pkg::count_t'(MAX_CHANNELS);

	cgr_pkg::gains_t  x;
	cgr_pkg::gains_t  xs;
	cgr_pkg::pair_t   pair;
	cgr_pkg::mode_t   mode;
	logic             supported;
	cgr_pkg::front_t  front;

	assign up_ready = !valid_s1 || down_ready;

	always_comb begin
		for (int i = 0; i < cgr_pkg::LANES; i++) begin
			x[i]  = (i < MAX_CHANNELS) ? in_gain[i] : '0;
			xs[i] = (cgr_pkg::count_t'(i) < src_count) ? x[i] : '0;
		end
	end

	always_comb begin
		pair = {src_count, dst_count};
		unique case (pair) inside
			cgr_pkg::PAIR_2_3, cgr_pkg::PAIR_2_4, cgr_pkg::PAIR_2_5, cgr_pkg::PAIR_2_6,
			cgr_pkg::PAIR_3_2, cgr_pkg::PAIR_3_4, cgr_pkg::PAIR_3_5, cgr_pkg::PAIR_3_6,
			cgr_pkg::PAIR_4_2, cgr_pkg::PAIR_4_3, cgr_pkg::PAIR_4_5, cgr_pkg::PAIR_4_6,
			cgr_pkg::PAIR_5_2, cgr_pkg::PAIR_5_3, cgr_pkg::PAIR_5_4, cgr_pkg::PAIR_5_6,
			cgr_pkg::PAIR_6_2, cgr_pkg::PAIR_6_3, cgr_pkg::PAIR_6_4, cgr_pkg::PAIR_6_5: begin
				supported = 1'b1;
			end
			default: begin
				supported = 1'b0;
			end
		endcase

		if (src_count > MAX_COUNT || dst_count > MAX_COUNT) begin
			mode = cgr_pkg::MODE_BAD;
		end else if (src_count == dst_count) begin
			mode = cgr_pkg::MODE_COPY;
		end else if (dst_count == 4'd1) begin
			// A mean over zero sources does not exist.
			mode = (src_count == 4'd0) ? cgr_pkg::MODE_BAD : cgr_pkg::MODE_MEAN;
		end else if (src_count == 4'd1) begin
			mode = cgr_pkg::MODE_BCAST;
		end else begin
			mode = supported ? cgr_pkg::MODE_MAP : cgr_pkg::MODE_BAD;
		end
	end

	always_comb begin
		front.ctl.mode = mode;
		front.ctl.pair = pair;
		front.ctl.dst  = dst_count;
		front.x        = x;
		for (int k = 0; k < 4; k++) begin
			front.psum[k] = {1'b0, xs[2*k]} + {1'b0, xs[2*k+1]};
		end
		front.s01   = {1'b0, x[0]} + {1'b0, x[1]};
		front.s23   = {1'b0, x[2]} + {1'b0, x[3]};
		front.h01   = cgr_pkg::half2(x[0], x[1]);
		front.h02   = cgr_pkg::half2(x[0], x[2]);
		front.h13   = cgr_pkg::half2(x[1], x[3]);
		front.h03   = cgr_pkg::half2(x[0], x[3]);
		front.h14   = cgr_pkg::half2(x[1], x[4]);
		front.h04   = cgr_pkg::half2(x[0], x[4]);
		front.h15   = cgr_pkg::half2(x[1], x[5]);
		front.recip = cgr_pkg::recip_of(src_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			front_s1 <= front;
		end
	end

endmodule

### rtl/cgr_map.sv
// Stage 2: lane selection for copy, broadcast and fixed map, and the mean's sum.
module cgr_map (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  cgr_pkg::front_t   front_s1,
	input  logic              down_ready,
	output logic              valid_s2,
	output cgr_pkg::map_t     map_s2
);

	cgr_pkg::gains_t  x;
	cgr_pkg::gains_t  y;
	cgr_pkg::gain_t   q4;
	cgr_pkg::gain_t   h43;
	logic [cgr_pkg::PSUM_W:0] qsum;
	cgr_pkg::sum_t    sum;
	cgr_pkg::map_t    map;

	assign up_ready = !valid_s2 || down_ready;
	assign x        = front_s1.x;

	always_comb begin
		sum  = cgr_pkg::sum_t'(front_s1.psum[0]) + cgr_pkg::sum_t'(front_s1.psum[1])
			+ cgr_pkg::sum_t'(front_s1.psum[2]) + cgr_pkg::sum_t'(front_s1.psum[3]);
		qsum = {1'b0, front_s1.s01} + {1'b0, front_s1.s23};
		q4   = qsum[cgr_pkg::PSUM_W:2];
		h43  = cgr_pkg::half2(front_s1.h02, front_s1.h13);
	end

	always_comb begin
		y = '0;
		unique case (front_s1.ctl.mode)
			cgr_pkg::MODE_COPY: begin
				y = x;
			end
			cgr_pkg::MODE_BCAST: begin
				for (int i = 0; i < cgr_pkg::LANES; i++) begin
					if (cgr_pkg::count_t'(i) < front_s1.ctl.dst) begin
						y[i] = x[0];
					end
				end
			end
			cgr_pkg::MODE_MAP: begin
				case (front_s1.ctl.pair)
					cgr_pkg::PAIR_2_3: begin
						y[0] = x[0]; y[1] = x[1]; y[2] = front_s1.h01;
					end
					cgr_pkg::PAIR_2_4: begin
						y[0] = x[0]; y[1] = x[1]; y[2] = x[0]; y[3] = x[1];
					end
					cgr_pkg::PAIR_2_5: begin
						y[0] = x[0]; y[1] = x[1]; y[2] = front_s1.h01;
						y[3] = x[0]; y[4] = x[1];
					end
					cgr_pkg::PAIR_2_6: begin
						y[0] = x[0]; y[1] = x[1]; y[2] = front_s1.h01;
						y[3] = front_s1.h01; y[4] = x[0]; y[5] = x[1];
					end
					cgr_pkg::PAIR_3_2: begin
						y[0] = x[0]; y[1] = x[1];
					end
					cgr_pkg::PAIR_3_4: begin
						y[0] = x[0]; y[1] = x[1]; y[2] = x[0]; y[3] = x[1];
					end
					cgr_pkg::PAIR_3_5: begin
						y[0] = x[0]; y[1] = x[1]; y[2] = x[2]; y[3] = x[0]; y[4] = x[1];
					end
					cgr_pkg::PAIR_3_6: begin
						y[0] = x[0]; y[1] = x[1]; y[2] = x[2]; y[3] = x[2];
						y[4] = x[0]; y[5] = x[1];
					end
					cgr_pkg::PAIR_4_2: begin
						y[0] = front_s1.h02; y[1] = front_s1.h13;
					end
					cgr_pkg::PAIR_4_3: begin
						y[0] = front_s1.h02; y[1] = front_s1.h13; y[2] = h43;
					end
					cgr_pkg::PAIR_4_5: begin
						y[0] = x[0]; y[1] = x[1]; y[2] = q4; y[3] = x[2]; y[4] = x[3];
					end
					cgr_pkg::PAIR_4_6: begin
						y[0] = x[0]; y[1] = x[1]; y[2] = q4; y[3] = q4;
						y[4] = x[2]; y[5] = x[3];
					end
					cgr_pkg::PAIR_5_2: begin
						y[0] = front_s1.h03; y[1] = front_s1.h14;
					end
					cgr_pkg::PAIR_5_3: begin
						y[0] = front_s1.h03; y[1] = front_s1.h14; y[2] = x[2];
					end
					cgr_pkg::PAIR_5_4: begin
						y[0] = x[0]; y[1] = x[1]; y[2] = x[3]; y[3] = x[4];
					end
					cgr_pkg::PAIR_5_6: begin
						y[0] = x[0]; y[1] = x[1]; y[2] = x[2]; y[3] = x[2];
						y[4] = x[3]; y[5] = x[4];
					end
					cgr_pkg::PAIR_6_2: begin
						y[0] = front_s1.h04; y[1] = front_s1.h15;
					end
					cgr_pkg::PAIR_6_3: begin
						y[0] = front_s1.h04; y[1] = front_s1.h15; y[2] = x[2];
					end
					cgr_pkg::PAIR_6_4: begin
						y[0] = x[0]; y[1] = x[1]; y[2] = x[4]; y[3] = x[5];
					end
					cgr_pkg::PAIR_6_5: begin
						y[0] = x[0]; y[1] = x[1]; y[2] = x[2]; y[3] = x[4]; y[4] = x[5];
					end
					default: begin
						y = '0;
					end
				endcase
			end
			default: begin
				// Errors and the mean leave every lane at zero here.
				y = '0;
			end
		endcase
	end

	always_comb begin
		map.ctl   = front_s1.ctl;
		map.y     = y;
		map.sum   = sum;
		map.recip = front_s1.recip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			map_s2 <= map;
		end
	end

endmodule

### rtl/cgr_mean.sv
// Stage 3: the mean's division as a multiplication by the source count's reciprocal.
module cgr_mean (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  cgr_pkg::map_t     map_s2,
	input  logic              down_ready,
	output logic              valid_s3,
	output cgr_pkg::mean_t    mean_s3
);

	cgr_pkg::mean_t mean;

	assign up_ready = !valid_s3 || down_ready;

	always_comb begin
		mean.ctl  = map_s2.ctl;
		mean.y    = map_s2.y;
		mean.prod = cgr_pkg::prod_t'(map_s2.sum) * cgr_pkg::prod_t'(map_s2.recip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			mean_s3 <= mean;
		end
	end

endmodule

### rtl/channel_gain_remap.sv
// Channel gain remapper: four-stage pipeline that turns source channel gains into
// destination gains. It takes one transfer per cycle while the response side keeps up,
// passing each through the front, map, mean and output registers; the path through each
// stage is one level of 17-bit adds, the lane selection beside a two-level 19-bit sum,
// the 19 by 25-bit multiply that forms the single-destination mean, or the final lane
// select. Each stage holds while its successor is full, so a stall on the response side
// fills the four stages and only then drops ready on the request side.
module channel_gain_remap #(
	parameter int MAX_CHANNELS = cgr_pkg::MAX_CHANNELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cgr_in_if.sink     req,
	cgr_out_if.source  rsp
);

	cgr_pkg::gains_t  in_gain;
	logic             rdy_s1;
	logic             rdy_s2;
	logic             rdy_s3;
	logic             rdy_s4;
	logic             valid_s1;
	logic             valid_s2;
	logic             valid_s3;
	logic             valid_s4;
	cgr_pkg::front_t  front_s1;
	cgr_pkg::map_t    map_s2;
	cgr_pkg::mean_t   mean_s3;
	logic             status_s4;
	cgr_pkg::gains_t  gain_s4;
	cgr_pkg::gains_t  gain_out;

	assign in_gain[0] = req.in_gain_0;
	assign in_gain[1] = req.in_gain_1;
	assign in_gain[2] = req.in_gain_2;
	assign in_gain[3] = req.in_gain_3;
	assign in_gain[4] = req.in_gain_4;
	assign in_gain[5] = req.in_gain_5;
	assign in_gain[6] = req.in_gain_6;
	assign in_gain[7] = req.in_gain_7;

	assign req.ready = rdy_s1;

	cgr_front #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (req.valid),
		.up_ready   (rdy_s1),
		.src_count  (req.src_count),
		.dst_count  (req.dst_count),
		.in_gain    (in_gain),
		.down_ready (rdy_s2),
		.valid_s1   (valid_s1),
		.front_s1   (front_s1)
	);

	cgr_map u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (valid_s1),
		.up_ready   (rdy_s2),
		.front_s1   (front_s1),
		.down_ready (rdy_s3),
		.valid_s2   (valid_s2),
		.map_s2     (map_s2)
	);

	cgr_mean u_mean (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (valid_s2),
		.up_ready   (rdy_s3),
		.map_s2     (map_s2),
		.down_ready (rdy_s4),
		.valid_s3   (valid_s3),
		.mean_s3    (mean_s3)
	);

	// Output stage: the mean replaces lane 0 when a single destination is wanted.
	assign rdy_s4 = !valid_s4 || rsp.ready;

	always_comb begin
		gain_out = mean_s3.y;
		if (mean_s3.ctl.mode == cgr_pkg::MODE_MEAN) begin
			gain_out[0] = mean_s3.prod[cgr_pkg::RECIP_SHIFT +: cgr_pkg::GAIN_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (rdy_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			status_s4 <= (mean_s3.ctl.mode == cgr_pkg::MODE_BAD);
			gain_s4   <= gain_out;
		end
	end

	assign rsp.valid      = valid_s4;
	assign rsp.status     = status_s4;
	assign rsp.out_gain_0 = gain_s4[0];
	assign rsp.out_gain_1 = gain_s4[1];
	assign rsp.out_gain_2 = gain_s4[2];
	assign rsp.out_gain_3 = gain_s4[3];
	assign rsp.out_gain_4 = gain_s4[4];
	assign rsp.out_gain_5 = gain_s4[5];
	assign rsp.out_gain_6 = gain_s4[6];
	assign rsp.out_gain_7 = gain_s4[7];

	// An error result carries no gains.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> gain_s4 == '0)
		else $error("error result with nonzero gains");

	// The mean only ever writes destination channel 0.
	a_mean_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && mean_s3.ctl.mode == cgr_pkg::MODE_MEAN |-> mean_s3.y == '0)
		else $error("mean transfer with other lanes set");

	// Backpressure reaches the request side only when every stage is full and stalled.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid && !rsp.ready && valid_s1 && valid_s2 && valid_s3)
		else $error("request stalled with a free stage");

	// A taken request is in the first stage on the next cycle.
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted request lost at entry");

endmodule
